FILE: rtl/core/tcvs_pkg.sv
// ----------------------------------------------------------------------------
// tcvs_pkg: shared types, codes and helpers for the voter store
// Row layout of the copy memory, action and register codes, the controller to
// datapath command and status groups, and the per-copy check word function.
// ----------------------------------------------------------------------------
package tcvs_pkg;

  localparam int COPIES = 3;
  localparam int WORD_W = 32;

  // Request actions
  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_SCRUB  = 2'd2;
  localparam logic [1:0] ACT_INJECT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEED0 = 2'd0;
  localparam logic [1:0] CFG_SEED1 = 2'd1;
  localparam logic [1:0] CFG_SEED2 = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    word_t check;
  } copy_t;

  typedef copy_t [COPIES-1:0] row_t;

  typedef word_t [COPIES-1:0] seeds_t;

  // Controller to datapath commands, at most one step per cycle
  typedef struct packed {
    logic load;      // capture the accepted request
    logic rd;        // read the addressed row
    logic chk;       // verify check words of the read row
    logic vote;      // pick winner and rewrite mask
    logic wr;        // write the row back and update counters
    logic next;      // advance to the next item during scrub
    logic out_load;  // capture the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scrub;  // current request walks all items
    logic last;   // current item is the last one
  } sts_t;

  // Seeded check word of one copy
  function automatic word_t check_word(input word_t v, input word_t seed);
    check_word = (v ^ seed) + (v << 7) + (v >> 3);
  endfunction

endpackage

FILE: rtl/core/tmr_checksum_voter_store.sv
// ----------------------------------------------------------------------------
// tmr_checksum_voter_store: triple-copy word store with checked majority vote
// Top level: seed registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with action, item_index, copy_select,
//   write_value and raw_check; each request gives exactly one result on
//   out_valid/out_stall (read_value, status, repair_total, unresolved_total).
//   Seeds are written through cfg_we/cfg_index/cfg_wdata while idle.
//   Each request runs read, check, vote and write-back of one memory row, one
//   step per cycle on the single row port of the copy memory; scrub runs
//   these steps for every item in turn. A request is accepted only after the
//   previous result is loaded, in the cycle after the load, even while that
//   result still waits at the output.
//   Reset clears seeds, counters, the output valid and the row valid bits, so
//   every item reads as zero value with zero check words.
//   A stalled result holds its payload; a finished request waits in its last
//   step until the output register frees up, with in_stall high meanwhile.
// ----------------------------------------------------------------------------
module tmr_checksum_voter_store
  import tcvs_pkg::*;
#(
  parameter int ITEMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_item_index,
  input  logic [1:0]  in_copy_select,
  input  logic [31:0] in_write_value,
  input  logic [31:0] in_raw_check,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  output logic        out_status,
  output logic [31:0] out_repair_total,
  output logic [31:0] out_unresolved_total
);

  seeds_t seed_r;
  cmd_t   cmd;
  sts_t   sts;

  // Seed registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED0: seed_r[0] <= cfg_wdata;
        CFG_SEED1: seed_r[1] <= cfg_wdata;
        CFG_SEED2: seed_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcvs_dp #(
    .ITEMS (ITEMS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .seed                 (seed_r),
    .in_action            (in_action),
    .in_item_index        (in_item_index),
    .in_copy_select       (in_copy_select),
    .in_write_value       (in_write_value),
    .in_raw_check         (in_raw_check),
    .out_read_value       (out_read_value),
    .out_status           (out_status),
    .out_repair_total     (out_repair_total),
    .out_unresolved_total (out_unresolved_total)
  );

endmodule

FILE: rtl/core/tcvs_ctrl.sv
// ----------------------------------------------------------------------------
// tcvs_ctrl: sequencer of the voter store
// Steps each request through read, check, vote and write-back, loops over all
// items for scrub, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tcvs_ctrl
  import tcvs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_VOTE  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.chk   = 1'b1;
        state_nxt = ST_VOTE;
      end
      ST_VOTE: begin
        cmd.vote  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.scrub && !sts.last) begin
          cmd.next  = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: drop when taken, raise on a new result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // At most one pipeline step is commanded per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd, cmd.chk, cmd.vote, cmd.wr}))
    else $error("more than one datapath step commanded");

  // An accepted request is read in the following cycle
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.rd)
    else $error("accepted request not followed by a row read");

  // A write-back either loops to the next item or finishes
  a_wr_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> (state_r == ST_READ || state_r == ST_DONE))
    else $error("write-back followed by an unexpected state");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded while previous result is stalled");

endmodule

FILE: rtl/core/tcvs_dp.sv
// ----------------------------------------------------------------------------
// tcvs_dp: datapath of the voter store
// Copy memory with one row per item, check word verification, majority vote,
// row rebuild for repair, set and inject, counters and the output register.
// ----------------------------------------------------------------------------
module tcvs_dp
  import tcvs_pkg::*;
#(
  parameter int ITEMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  seeds_t      seed,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_item_index,
  input  logic [1:0]  in_copy_select,
  input  logic [31:0] in_write_value,
  input  logic [31:0] in_raw_check,
  output logic [31:0] out_read_value,
  output logic        out_status,
  output logic [31:0] out_repair_total,
  output logic [31:0] out_unresolved_total
);

  localparam int AW = (ITEMS > 1) ? $clog2(ITEMS) : 1;

  // Request registers
  logic [1:0]        op_r;
  logic [AW-1:0]     addr_r;
  logic              en_r;
  logic [1:0]        cs_r;
  word_t             wv_r;
  word_t             rc_r;
  logic              in_range;

  // Memory and read path
  row_t              mem [ITEMS];
  logic [ITEMS-1:0]  vld_r;
  row_t              mem_q;
  logic              rd_vld_r;
  row_t              row_q;

  // Vote path
  logic [COPIES-1:0] ok_r, ok_nxt;
  logic [COPIES-1:0] mask_r, mask_nxt;
  logic [COPIES-1:0] inj_r, inj_nxt;
  word_t             win_r, win_nxt;
  logic              maj_r, maj_nxt;
  logic              eq01, eq02, eq12, a01, a02, a12;
  row_t              row_new;
  logic              is_vote_op;

  // Counters and result
  word_t             repair_r, unres_r;
  logic              unst_r;
  word_t             rv_r, rep_out_r, unres_out_r;
  logic              st_r;

  assign in_range   = ({7'd0, in_item_index} < 9'(ITEMS));
  assign is_vote_op = (op_r == ACT_GET) || (op_r == ACT_SCRUB);
  assign sts.scrub  = (op_r == ACT_SCRUB);
  assign sts.last   = (addr_r == AW'(ITEMS - 1));

  // Capture the request, advance the item during scrub
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_action;
      cs_r <= in_copy_select;
      wv_r <= in_write_value;
      rc_r <= in_raw_check;
      if (in_action == ACT_SCRUB) begin
        addr_r <= '0;
        en_r   <= 1'b1;
      end else begin
        addr_r <= in_range ? AW'(in_item_index) : '0;
        en_r   <= in_range;
      end
    end else if (cmd.next) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  // Copy memory: one row per item, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_q    <= mem[addr_r];
      rd_vld_r <= vld_r[addr_r];
    end
    if (cmd.wr && en_r) mem[addr_r] <= row_new;
  end

  // Row valid bits: an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr && en_r) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  assign row_q = rd_vld_r ? mem_q : '0;

  // Verify each copy against its seeded check word
  always_comb begin
    for (int c = 0; c < COPIES; c++) begin
      ok_nxt[c] = (row_q[c].check == check_word(row_q[c].value, seed[c]));
    end
  end

  // Majority among intact copies; first winner in copy order
  assign eq01 = (row_q[0].value == row_q[1].value);
  assign eq02 = (row_q[0].value == row_q[2].value);
  assign eq12 = (row_q[1].value == row_q[2].value);
  assign a01  = ok_r[0] && ok_r[1] && eq01;
  assign a02  = ok_r[0] && ok_r[2] && eq02;
  assign a12  = ok_r[1] && ok_r[2] && eq12;

  always_comb begin
    maj_nxt  = 1'b0;
    win_nxt  = '0;
    mask_nxt = '0;
    inj_nxt  = '0;
    case (op_r)
      ACT_SET: begin
        win_nxt  = wv_r;
        mask_nxt = '1;
      end
      ACT_INJECT: begin
        for (int c = 0; c < COPIES; c++) inj_nxt[c] = (cs_r == 2'(c));
      end
      default: begin
        if (a01 || a02) begin
          maj_nxt     = 1'b1;
          win_nxt     = row_q[0].value;
          mask_nxt[1] = !ok_r[1] || !eq01;
          mask_nxt[2] = !ok_r[2] || !eq02;
        end else if (a12) begin
          maj_nxt     = 1'b1;
          win_nxt     = row_q[1].value;
          mask_nxt[0] = !ok_r[0] || !eq01;
          mask_nxt[2] = !ok_r[2] || !eq12;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) ok_r <= ok_nxt;
    if (cmd.vote) begin
      maj_r  <= maj_nxt;
      win_r  <= win_nxt;
      mask_r <= mask_nxt;
      inj_r  <= inj_nxt;
    end
  end

  // Rebuild the row: rewrite repaired copies, drop in injected copy
  always_comb begin
    for (int c = 0; c < COPIES; c++) begin
      if (mask_r[c]) begin
        row_new[c].value = win_r;
        row_new[c].check = check_word(win_r, seed[c]);
      end else if (inj_r[c]) begin
        row_new[c].value = wv_r;
        row_new[c].check = rc_r;
      end else begin
        row_new[c] = row_q[c];
      end
    end
  end

  // Repair and unresolved counters, request-wide unstable flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repair_r <= '0;
      unres_r  <= '0;
      unst_r   <= 1'b0;
    end else if (cmd.load) begin
      unst_r <= 1'b0;
    end else if (cmd.wr && en_r && is_vote_op) begin
      repair_r <= repair_r + WORD_W'(mask_r[0]) + WORD_W'(mask_r[1])
                  + WORD_W'(mask_r[2]);
      if (!maj_r) begin
        unres_r <= unres_r + WORD_W'(1);
        unst_r  <= 1'b1;
      end
    end
  end

  // Output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rv_r        <= (op_r == ACT_GET && en_r && maj_r) ? win_r : '0;
      st_r        <= unst_r;
      rep_out_r   <= repair_r;
      unres_out_r <= unres_r;
    end
  end

  assign out_read_value       = rv_r;
  assign out_status           = st_r;
  assign out_repair_total     = rep_out_r;
  assign out_unresolved_total = unres_out_r;

endmodule

FILE: test/tcvs_vote_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcvs_vote_checker: shadow voter and result scoreboard for the voter store
// Watches the seed writes, the request channel and the result channel. Keeps a
// shadow copy of the triple-copy store, votes it the same way the block must,
// and compares every delivered result field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module tcvs_vote_checker
  import tcvs_pkg::*;
#(
  parameter int ITEMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_item_index,
  input  logic [1:0]  in_copy_select,
  input  logic [31:0] in_write_value,
  input  logic [31:0] in_raw_check,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_read_value,
  input  logic        out_status,
  input  logic [31:0] out_repair_total,
  input  logic [31:0] out_unresolved_total,
  output int          fail_count,
  output int          pend_count,
  output int          result_count
);

  typedef struct packed {
    word_t read_value;
    logic  status;
    word_t repair_total;
    word_t unresolved_total;
  } vote_reply_t;

  vote_reply_t awaited_replies[$];

  // Shadow of the store: copy c of item i sits at COPIES*i + c
  word_t shadow_seed[COPIES];
  word_t shadow_value[COPIES*ITEMS];
  word_t shadow_check[COPIES*ITEMS];
  word_t shadow_repairs;
  word_t shadow_unresolved;

  initial begin
    fail_count   = 0;
    pend_count   = 0;
    result_count = 0;
  end

  function automatic word_t seeded_sum(input word_t v, input word_t seed);
    return (v ^ seed) + (v << 7) + (v >> 3);
  endfunction

  function automatic bit copy_sound(input int slot, input int c);
    return shadow_check[slot] == seeded_sum(shadow_value[slot], shadow_seed[c]);
  endfunction

  // Vote one item of the shadow; rewrite losers and bump the counters
  function automatic bit vote_shadow_item(input int item, output word_t winner);
    int base;
    int agree;
    bit sound[COPIES];
    word_t w;
    base = item * COPIES;
    for (int i = 0; i < COPIES; i++) sound[i] = copy_sound(base + i, i);
    for (int i = 0; i < COPIES; i++) begin
      if (!sound[i]) continue;
      agree = 1;
      for (int j = 0; j < COPIES; j++) begin
        if (j != i && sound[j] && shadow_value[base + j] == shadow_value[base + i]) agree++;
      end
      if (agree >= 2) begin
        w = shadow_value[base + i];
        for (int j = 0; j < COPIES; j++) begin
          if (!copy_sound(base + j, j) || shadow_value[base + j] != w) begin
            shadow_value[base + j] = w;
            shadow_check[base + j] = seeded_sum(w, shadow_seed[j]);
            shadow_repairs++;
          end
        end
        winner = w;
        return 1'b1;
      end
    end
    shadow_unresolved++;
    winner = '0;
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Track seeds, predict each accepted request, check each delivered result
  always @(posedge clk) begin : watch
    vote_reply_t owed;
    vote_reply_t fresh;
    word_t win;
    int item;
    int base;
    if (!rst_n) begin
      for (int c = 0; c < COPIES; c++) shadow_seed[c] = '0;
      for (int k = 0; k < COPIES*ITEMS; k++) begin
        shadow_value[k] = '0;
        shadow_check[k] = '0;
      end
      shadow_repairs    = '0;
      shadow_unresolved = '0;
      awaited_replies.delete();
    end else begin
      // check the delivered result against the oldest one owed
      if (out_valid && !out_stall) begin
        result_count++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h status %b",
                   $time, out_read_value, out_status);
          fail_count++;
        end else begin
          owed = awaited_replies.pop_front();
          compare_field("read_value", owed.read_value, out_read_value);
          compare_field("status", word_t'(owed.status), word_t'(out_status));
          compare_field("repair_total", owed.repair_total, out_repair_total);
          compare_field("unresolved_total", owed.unresolved_total, out_unresolved_total);
        end
      end

      if (cfg_we && int'(cfg_index) < COPIES) shadow_seed[cfg_index] = cfg_wdata;

      // predict the result of the accepted request
      if (in_valid && !in_stall) begin
        fresh = '0;
        item  = int'(in_item_index);
        base  = item * COPIES;
        case (in_action)
          ACT_SET: begin
            if (item < ITEMS) begin
              for (int c = 0; c < COPIES; c++) begin
                shadow_value[base + c] = in_write_value;
                shadow_check[base + c] = seeded_sum(in_write_value, shadow_seed[c]);
              end
            end
          end
          ACT_GET: begin
            if (item < ITEMS) begin
              if (vote_shadow_item(item, win)) fresh.read_value = win;
              else fresh.status = 1'b1;
            end
          end
          ACT_SCRUB: begin
            for (int k = 0; k < ITEMS; k++) begin
              if (!vote_shadow_item(k, win)) fresh.status = 1'b1;
            end
          end
          default: begin
            if (item < ITEMS && int'(in_copy_select) < COPIES) begin
              shadow_value[base + in_copy_select] = in_write_value;
              shadow_check[base + in_copy_select] = in_raw_check;
            end
          end
        endcase
        fresh.repair_total     = shadow_repairs;
        fresh.unresolved_total = shadow_unresolved;
        awaited_replies.push_back(fresh);
      end
    end
    pend_count = awaited_replies.size();
  end

endmodule

FILE: test/tb_tmr_checksum_voter_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tmr_checksum_voter_store: request-level test of the voter store
// Drives a directed walk through the vote cases, then random set, get, scrub
// and inject traffic under four seed settings with random idling on both
// channels. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tmr_checksum_voter_store;
  import tcvs_pkg::*;

  localparam int ITEMS_N = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [1:0]  in_item_index = '0;
  logic [1:0]  in_copy_select = '0;
  logic [31:0] in_write_value = '0;
  logic [31:0] in_raw_check = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_value;
  logic        out_status;
  logic [31:0] out_repair_total;
  logic [31:0] out_unresolved_total;

  int    fail_count;
  int    pend_count;
  int    result_count;
  int    request_count = 0;
  bit    calm = 1'b0;
  word_t seed_now[COPIES] = '{default: '0};
  word_t value_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};

  always #5 clk = ~clk;

  tmr_checksum_voter_store #(.ITEMS(ITEMS_N)) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_item_index        (in_item_index),
    .in_copy_select       (in_copy_select),
    .in_write_value       (in_write_value),
    .in_raw_check         (in_raw_check),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_value       (out_read_value),
    .out_status           (out_status),
    .out_repair_total     (out_repair_total),
    .out_unresolved_total (out_unresolved_total)
  );

  tcvs_vote_checker #(.ITEMS(ITEMS_N)) u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_item_index        (in_item_index),
    .in_copy_select       (in_copy_select),
    .in_write_value       (in_write_value),
    .in_raw_check         (in_raw_check),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_value       (out_read_value),
    .out_status           (out_status),
    .out_repair_total     (out_repair_total),
    .out_unresolved_total (out_unresolved_total),
    .fail_count           (fail_count),
    .pend_count           (pend_count),
    .result_count         (result_count)
  );

  // Offer one request, with an optional idle burst first; hold until accepted
  task automatic send_request(input logic [1:0] act, input logic [1:0] item,
                              input logic [1:0] sel, input word_t val, input word_t chk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_item_index  <= item;
    in_copy_select <= sel;
    in_write_value <= val;
    in_raw_check   <= chk;
    do @(posedge clk); while (in_stall);
    request_count++;
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pend_count == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(input logic [1:0] idx, input word_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_now[idx] = data;
  endtask

  // Intact copy under the seed in force for that copy
  function automatic word_t sealed(input logic [1:0] sel, input word_t val);
    return check_word(val, seed_now[sel]);
  endfunction

  // Weighted random request: sets and injects build up the vote cases
  task automatic random_request();
    int    roll;
    logic [1:0] item;
    logic [1:0] sel;
    word_t val;
    word_t chk;
    roll = $urandom_range(0, 99);
    item = 2'($urandom_range(0, 3));
    sel  = 2'($urandom_range(0, 3));
    val  = ($urandom_range(0, 2) == 0) ? $urandom : value_pool[$urandom_range(0, 3)];
    chk  = $urandom;
    if (roll < 20) begin
      send_request(ACT_SET, item, sel, val, chk);
    end else if (roll < 55) begin
      send_request(ACT_GET, item, sel, val, chk);
    end else if (roll < 62) begin
      send_request(ACT_SCRUB, item, sel, val, chk);
    end else begin
      if (roll < 66) sel = 2'd3;
      else sel = 2'($urandom_range(0, 2));
      if (sel != 2'd3 && $urandom_range(0, 9) < 6) chk = sealed(sel, val);
      send_request(ACT_INJECT, item, sel, val, chk);
    end
  endtask

  // Random stall bursts on the result side
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop on a hang
  initial begin
    #5_000_000;
    $display("tb_tmr_checksum_voter_store: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, extremes, single and double upsets
    send_request(ACT_GET, 2'd0, 2'd0, '0, '0);
    send_request(ACT_SET, 2'd0, 2'd0, 32'hFFFF_FFFF, '0);
    send_request(ACT_SET, 2'd3, 2'd1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_GET, 2'd0, 2'd0, '0, '0);
    send_request(ACT_INJECT, 2'd0, 2'd0, 32'h1234_5678, 32'h0000_0000);
    send_request(ACT_GET, 2'd0, 2'd0, '0, '0);
    send_request(ACT_INJECT, 2'd1, 2'd1, 32'hA5A5_A5A5, sealed(2'd1, 32'hA5A5_A5A5));
    send_request(ACT_GET, 2'd1, 2'd0, '0, '0);
    send_request(ACT_INJECT, 2'd2, 2'd0, 32'h0000_0001, 32'hDEAD_BEEF);
    send_request(ACT_INJECT, 2'd2, 2'd1, 32'h8000_0000, 32'h0000_0001);
    send_request(ACT_GET, 2'd2, 2'd0, '0, '0);
    send_request(ACT_SCRUB, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // copy select past the last copy leaves the item alone
    send_request(ACT_INJECT, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_GET, 2'd3, 2'd0, '0, '0);
    // intact but split: first copy disagrees, the later two win
    send_request(ACT_INJECT, 2'd1, 2'd0, 32'h0000_0009, sealed(2'd0, 32'h0000_0009));
    send_request(ACT_INJECT, 2'd1, 2'd1, 32'h0000_0005, sealed(2'd1, 32'h0000_0005));
    send_request(ACT_INJECT, 2'd1, 2'd2, 32'h0000_0005, sealed(2'd2, 32'h0000_0005));
    send_request(ACT_GET, 2'd1, 2'd0, '0, '0);
    send_request(ACT_GET, 2'd1, 2'd0, '0, '0);
    // only the last copy intact, the other two corrupted: no majority
    send_request(ACT_INJECT, 2'd2, 2'd2, 32'h0000_0003, sealed(2'd2, 32'h0000_0003));
    send_request(ACT_GET, 2'd2, 2'd0, '0, '0);

    // New seeds turn every stored copy stale
    drain_requests();
    write_seed(CFG_SEED0, 32'hFFFF_FFFF);
    write_seed(CFG_SEED1, 32'hFFFF_FFFF);
    write_seed(CFG_SEED2, 32'hFFFF_FFFF);
    send_request(ACT_GET, 2'd0, 2'd0, '0, '0);
    send_request(ACT_SCRUB, 2'd0, 2'd0, '0, '0);
    repeat (100) random_request();

    drain_requests();
    write_seed(CFG_SEED0, $urandom);
    write_seed(CFG_SEED1, $urandom);
    write_seed(CFG_SEED2, $urandom);
    repeat (100) random_request();

    drain_requests();
    write_seed(CFG_SEED0, 32'h0000_0000);
    write_seed(CFG_SEED1, 32'h8000_0000);
    write_seed(CFG_SEED2, $urandom);
    repeat (50) random_request();
    drain_requests();
    repeat (50) random_request();

    // Last phase back at reset seeds, the tail without any idling
    drain_requests();
    write_seed(CFG_SEED0, 32'h0000_0000);
    write_seed(CFG_SEED1, 32'h0000_0000);
    write_seed(CFG_SEED2, 32'h0000_0000);
    repeat (40) random_request();
    calm = 1'b1;
    repeat (60) random_request();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pend_count == 0);
    repeat (20) @(posedge clk);

    $display("covered: %0d requests, %0d results, directed vote cases and four seed settings",
             request_count, result_count);
    $display("mismatches: %0d, results still owed: %0d", fail_count, pend_count);
    if (fail_count == 0 && pend_count == 0) begin
      $display("tb_tmr_checksum_voter_store: done, clean");
    end else begin
      $display("tb_tmr_checksum_voter_store: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tcvs_pkg.sv
rtl/core/tcvs_ctrl.sv
rtl/core/tcvs_dp.sv
rtl/core/tmr_checksum_voter_store.sv
test/tcvs_vote_checker.sv
test/tb_tmr_checksum_voter_store.sv
